@@ rtl/rcm_pkg.sv @@
// ----------------------------------------------------------------------------
// rcm_pkg: shared types and constants for the rectified current meter
// Action and result codes, the sequencer state type and the fixed sizes
// used by the meter datapath.
// ----------------------------------------------------------------------------
package rcm_pkg;

   // adc word size and midscale offset
   localparam int SAMPLE_BITS = 10;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

   // accumulator widths
   localparam int PERIOD_BITS = 17;
   localparam int WINDOW_BITS = 25;
   localparam int TARGET_BITS = 24;
   localparam int VALUE_BITS  = 32;

   // register reset values
   localparam logic [7:0] SPP_RESET = 8'd90;
   localparam logic [7:0] PPR_RESET = 8'd50;

   // largest q16.8 target
   localparam logic [TARGET_BITS-1:0] TARGET_MAX = '1;

   // configuration register indexes
   localparam logic [7:0] REG_SAMPLES_PER_PERIOD = 8'd0;
   localparam logic [7:0] REG_PERIODS_PER_REPORT = 8'd1;

   // input actions
   typedef enum logic [1:0] {
      ACT_SAMPLE  = 2'd0,
      ACT_ARM     = 2'd1,
      ACT_RESTORE = 2'd2,
      ACT_UNUSED  = 2'd3
   } action_type;

   // result kinds
   typedef enum logic {
      KIND_REPORT = 1'b0,
      KIND_SCALE  = 1'b1
   } kind_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_CHECK  = 2'd1,
      ST_DIVIDE = 2'd2,
      ST_DONE   = 2'd3
   } state_type;

endpackage

@@ rtl/rectified_current_meter.sv @@
// ----------------------------------------------------------------------------
// rectified_current_meter: rectified-average ac current meter
// Sums |sample - midscale| over each mains period and the period sums over a
// report window, then divides the window sum to report a q24.8 measurement
// or to derive a new q16.16 calibration scale.
// ----------------------------------------------------------------------------
//
// Usage:
// - req_ carries one transaction per sample, calibration arm or scale restore
//   (action in req_tuser). Samples, arm and restore are taken while the
//   block is idle; the sample that closes a report window drops req_tready.
// - On the sample that closes a report window the block runs one shared
//   restoring divider, one quotient bit per cycle. It loads the divider,
//   runs a range check, divides out the 32 quotient bits and hands the
//   result to the output register. req_tready is low meanwhile.
//   A zero divisor or a quotient that does not fit 32 bits skips the divide.
// - rsp_ carries at most one result per window. The result sits in an output
//   register; new samples are taken while it waits. If another window ends
//   before it is taken, the sequencer holds its result and stays busy until
//   the output register frees up.
// - csr_ writes samples_per_period (index 0) and periods_per_report
//   (index 1); csr_ready is always high, other indexes are ignored.
// - reset clears all accumulators, the armed target and the scale, loads the
// register defaults (90 and 50) and empties the output register. There is
// no clearing pass; the block is ready as soon as reset is released.
//
module rectified_current_meter (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // sample [9:0], argument [41:10], zero [47:42]
   input  logic [1:0]  req_tuser,   // action [1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value [31:0]
   output logic [1:0]  rsp_tuser,   // kind [0], saturated [1]
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int PB = rcm_pkg::PERIOD_BITS;
   localparam int WB = rcm_pkg::WINDOW_BITS;
   localparam int TB = rcm_pkg::TARGET_BITS;
   localparam int VB = rcm_pkg::VALUE_BITS;
   localparam int SB = rcm_pkg::SAMPLE_BITS;

   // registers
   rcm_pkg::state_type state_ff, state_in;
   logic [7:0]    spp_ff, spp_in;
   logic [7:0]    ppr_ff, ppr_in;
   logic [PB-1:0] period_sum_ff, period_sum_in;
   logic [WB-1:0] window_sum_ff, window_sum_in;
   logic [7:0]    sample_count_ff, sample_count_in;
   logic [7:0]    period_count_ff, period_count_in;
   logic [TB-1:0] target_ff, target_in;
   logic [VB-1:0] scale_ff, scale_in;
   // divider
   logic [WB-1:0] num_ff, num_in;
   logic [VB-1:0] den_ff, den_in;
   logic [VB-1:0] rem_ff, rem_in;
   logic [7:0]    low_ff, low_in;
   logic [VB-1:0] quo_ff, quo_in;
   logic [4:0]    step_ff, step_in;
   rcm_pkg::kind_type kind_ff, kind_in;
   logic          sat_ff, sat_in;
   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VB-1:0] rsp_value_ff, rsp_value_in;
   rcm_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic          rsp_sat_ff, rsp_sat_in;

   // combinational helpers
   rcm_pkg::action_type action;
   logic [SB-1:0] smp;
   logic [SB-1:0] mag;
   logic [PB-1:0] period_next;
   logic [WB-1:0] window_next;
   logic [7:0]    sample_inc;
   logic [7:0]    period_inc;
   logic          period_end;
   logic          window_end;
   logic [VB:0]   trial;
   logic [VB+1:0] diff;
   logic          ge;
   logic          overflow;
   logic          req_fire;
   logic          rsp_free;

   assign action    = rcm_pkg::action_type'(req_tuser);
   assign smp       = req_tdata[SB-1:0];
   assign req_tready = (state_ff == rcm_pkg::ST_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   // sample rectification and accumulation
   assign mag         = (smp >= rcm_pkg::SAMPLE_MID) ? smp - rcm_pkg::SAMPLE_MID
                                                     : rcm_pkg::SAMPLE_MID - smp;
   assign period_next = period_sum_ff + PB'(mag);
   assign sample_inc  = sample_count_ff + 8'd1;
   assign period_end  = !(sample_inc < spp_ff);
   assign window_next = window_sum_ff + WB'(period_next);
   assign period_inc  = period_count_ff + 8'd1;
   assign window_end  = period_end && !(period_inc < ppr_ff);

   // divider step and range check
   assign trial    = {rem_ff, low_ff[7]};
   assign diff     = {1'b0, trial} - {2'b00, den_ff};
   assign ge       = !diff[VB+1];
   assign overflow = ({{(VB + 8 - WB){1'b0}}, num_ff} >= {den_ff, 8'd0});

   // sequencer, state and datapath next values
   always_comb begin
      state_in        = state_ff;
      spp_in          = spp_ff;
      ppr_in          = ppr_ff;
      period_sum_in   = period_sum_ff;
      window_sum_in   = window_sum_ff;
      sample_count_in = sample_count_ff;
      period_count_in = period_count_ff;
      target_in       = target_ff;
      scale_in        = scale_ff;
      num_in          = num_ff;
      den_in          = den_ff;
      rem_in          = rem_ff;
      low_in          = low_ff;
      quo_in          = quo_ff;
      step_in         = step_ff;
      kind_in         = kind_ff;
      sat_in          = sat_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_value_in    = rsp_value_ff;
      rsp_kind_in     = rsp_kind_ff;
      rsp_sat_in      = rsp_sat_ff;

      // configuration writes
      if (csr_valid) begin
         if (csr_index == rcm_pkg::REG_SAMPLES_PER_PERIOD) begin
            spp_in = csr_wdata;
         end
         if (csr_index == rcm_pkg::REG_PERIODS_PER_REPORT) begin
            ppr_in = csr_wdata;
         end
      end

      case (state_ff)
         rcm_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (action)
                  rcm_pkg::ACT_SAMPLE: begin
                     if (!period_end) begin
                        period_sum_in   = period_next;
                        sample_count_in = sample_inc;
                     end else begin
                        period_sum_in   = '0;
                        sample_count_in = '0;
                        if (!window_end) begin
                           window_sum_in   = window_next;
                           period_count_in = period_inc;
                        end else begin
                           // window closed: load the divider
                           window_sum_in   = '0;
                           period_count_in = '0;
                           num_in          = window_next;
                           if (target_ff != '0) begin
                              den_in    = {{(VB - TB){1'b0}}, target_ff};
                              kind_in   = rcm_pkg::KIND_SCALE;
                              target_in = '0;
                           end else begin
                              den_in  = scale_ff;
                              kind_in = rcm_pkg::KIND_REPORT;
                           end
                           state_in = rcm_pkg::ST_CHECK;
                        end
                     end
                  end
                  rcm_pkg::ACT_ARM: begin
                     if (req_tdata[41:10] > {{(VB - TB){1'b0}}, rcm_pkg::TARGET_MAX}) begin
                        target_in = rcm_pkg::TARGET_MAX;
                     end else begin
                        target_in = req_tdata[TB+9:10];
                     end
                  end
                  rcm_pkg::ACT_RESTORE: begin
                     scale_in = req_tdata[41:10];
                  end
                  default: begin
                  end
               endcase
            end
         end
         rcm_pkg::ST_CHECK: begin
            // zero divisor or quotient wider than 32 bits saturates
            if (den_ff == '0 || overflow) begin
               sat_in   = 1'b1;
               quo_in   = '1;
               state_in = rcm_pkg::ST_DONE;
            end else begin
               sat_in   = 1'b0;
               rem_in   = {{(VB - (WB - 8)){1'b0}}, num_ff[WB-1:8]};
               low_in   = num_ff[7:0];
               quo_in   = '0;
               step_in  = '0;
               state_in = rcm_pkg::ST_DIVIDE;
            end
         end
         rcm_pkg::ST_DIVIDE: begin
            // one restoring quotient bit per cycle
            rem_in  = ge ? diff[VB-1:0] : trial[VB-1:0];
            quo_in  = {quo_ff[VB-2:0], ge};
            low_in  = {low_ff[6:0], 1'b0};
            step_in = step_ff + 5'd1;
            if (step_ff == '1) begin
               state_in = rcm_pkg::ST_DONE;
            end
         end
         rcm_pkg::ST_DONE: begin
            // hand off once the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = quo_ff;
               rsp_kind_in  = kind_ff;
               rsp_sat_in   = sat_ff;
               if (kind_ff == rcm_pkg::KIND_SCALE) begin
                  scale_in = quo_ff;
               end
               state_in = rcm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rcm_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= rcm_pkg::ST_IDLE;
         spp_ff          <= rcm_pkg::SPP_RESET;
         ppr_ff          <= rcm_pkg::PPR_RESET;
         period_sum_ff   <= '0;
         window_sum_ff   <= '0;
         sample_count_ff <= '0;
         period_count_ff <= '0;
         target_ff       <= '0;
         scale_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         spp_ff          <= spp_in;
         ppr_ff          <= ppr_in;
         period_sum_ff   <= period_sum_in;
         window_sum_ff   <= window_sum_in;
         sample_count_ff <= sample_count_in;
         period_count_ff <= period_count_in;
         target_ff       <= target_in;
         scale_ff        <= scale_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // divider and output payload
   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      low_ff       <= low_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      kind_ff      <= kind_in;
      sat_ff       <= sat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_kind_ff};

endmodule

@@ tb/sv/rectified_current_meter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectified_current_meter_tb: self-checking bench for the current meter
// Drives ADC samples, calibration arms and scale restores through the
// request stream and reprograms the period and window lengths between
// phases. A scoreboard keeps its own copy of the accumulators and computes
// each report and calibration result for comparison in order.
// ----------------------------------------------------------------------------
module rectified_current_meter_tb;

   localparam int CLK_PERIOD     = 12;
   localparam int RANDOM_ITEMS   = 600;
   localparam int TAIL_ITEMS     = 100;
   localparam int SETTLE_CYCLES  = 48;
   localparam int DRAIN_CYCLES   = 64;
   localparam int LONG_HOLD      = 300;
   localparam int TIMEOUT_CYCLES = 2_500_000;

   typedef struct packed {
      rcm_pkg::kind_type kind;
      logic [31:0]       value;
      logic              saturated;
   } meter_result_type;

   // scoreboard: mirrors the meter state and queues the expected results
   class meter_scoreboard;
      logic [7:0]          spp;
      logic [7:0]          ppr;
      logic [16:0]         period_sum;
      logic [24:0]         window_sum;
      logic [7:0]          sample_count;
      logic [7:0]          period_count;
      logic [23:0]         armed_target;
      logic [31:0]         scale;
      meter_result_type    expected_readings[$];
      int                  mismatches;
      int                  samples;
      int                  arms;
      int                  restores;
      int                  ignored;
      int                  reg_writes;
      int                  reports;
      int                  calibrations;
      int                  saturations;

      function new();
         spp = rcm_pkg::SPP_RESET;
         ppr = rcm_pkg::PPR_RESET;
         period_sum = '0;
         window_sum = '0;
         sample_count = '0;
         period_count = '0;
         armed_target = '0;
         scale = '0;
         mismatches = 0;
         samples = 0;
         arms = 0;
         restores = 0;
         ignored = 0;
         reg_writes = 0;
         reports = 0;
         calibrations = 0;
         saturations = 0;
      endfunction

      function int outstanding();
         return expected_readings.size();
      endfunction

      function void load_register(logic [7:0] index, logic [7:0] data);
         reg_writes++;
         if (index == rcm_pkg::REG_SAMPLES_PER_PERIOD)
            spp = data;
         else if (index == rcm_pkg::REG_PERIODS_PER_REPORT)
            ppr = data;
      endfunction

      // (window_sum << 24) / divisor, bit 32 flags overflow or zero divisor
      function logic [32:0] scaled_quotient(logic [24:0] num, logic [31:0] den);
         logic [63:0] q;
         if (den == '0)
            return {1'b1, 32'hFFFF_FFFF};
         q = {15'd0, num, 24'd0} / {32'd0, den};
         if (q[63:32] != '0)
            return {1'b1, 32'hFFFF_FFFF};
         return {1'b0, q[31:0]};
      endfunction

      // advance the mirrored state by one accepted request transaction
      function void note_input(rcm_pkg::action_type act,
                               logic [rcm_pkg::SAMPLE_BITS-1:0] adc_code,
                               logic [31:0] arg);
         logic [rcm_pkg::SAMPLE_BITS-1:0] mag;
         logic [32:0]                     quot;
         meter_result_type                res;
         case (act)
            rcm_pkg::ACT_ARM: begin
               armed_target = (arg > {8'd0, rcm_pkg::TARGET_MAX}) ?
                              rcm_pkg::TARGET_MAX : arg[23:0];
               arms++;
               return;
            end
            rcm_pkg::ACT_RESTORE: begin
               scale = arg;
               restores++;
               return;
            end
            rcm_pkg::ACT_SAMPLE: ;
            default: begin
               ignored++;
               return;
            end
         endcase
         samples++;
         mag = (adc_code >= rcm_pkg::SAMPLE_MID) ? adc_code - rcm_pkg::SAMPLE_MID
                                                 : rcm_pkg::SAMPLE_MID - adc_code;
         period_sum = period_sum + 17'(mag);

         // period end
         sample_count = sample_count + 8'd1;
         if (sample_count < spp)
            return;
         sample_count = '0;
         window_sum = window_sum + 25'(period_sum);
         period_sum = '0;

         // window end: calibrate when armed, otherwise report
         period_count = period_count + 8'd1;
         if (period_count < ppr)
            return;
         period_count = '0;
         if (armed_target != '0) begin
            quot = scaled_quotient(window_sum, {8'd0, armed_target});
            scale = quot[31:0];
            armed_target = '0;
            res.kind = rcm_pkg::KIND_SCALE;
         end else begin
            quot = scaled_quotient(window_sum, scale);
            res.kind = rcm_pkg::KIND_REPORT;
         end
         res.value = quot[31:0];
         res.saturated = quot[32];
         expected_readings.push_back(res);
         window_sum = '0;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("%0t ns mismatch: %s", $time, what);
      endtask

      // compare one result transaction with the oldest expectation
      task check_result(rcm_pkg::kind_type kind, logic [31:0] value, logic saturated);
         meter_result_type want;
         if (expected_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d value %h sat %b",
                                      kind, value, saturated));
            return;
         end
         want = expected_readings.pop_front();
         if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
         if (value !== want.value)
            report_mismatch($sformatf("value %h, expected %h", value, want.value));
         if (saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, expected %b", saturated,
                                      want.saturated));
         if (want.kind == rcm_pkg::KIND_SCALE)
            calibrations++;
         else
            reports++;
         if (want.saturated)
            saturations++;
      endtask

      task close_out();
         while (expected_readings.size() != 0) begin
            void'(expected_readings.pop_front());
            report_mismatch("expected result never arrived");
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // sample [9:0], argument [41:10], zero [47:42]
   logic [1:0]  req_tuser = '0;   // action [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // value [31:0]
   logic [1:0]  rsp_tuser;        // kind [0], saturated [1]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   meter_scoreboard meter;
   logic            src_gaps = 1'b0;
   logic            sink_gaps = 1'b0;
   logic            long_hold_req = 1'b0;
   int              items_driven = 0;

   rectified_current_meter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            meter.load_register(csr_index, csr_wdata);
         if (req_tvalid && req_tready)
            meter.note_input(rcm_pkg::action_type'(req_tuser),
                             req_tdata[rcm_pkg::SAMPLE_BITS-1:0],
                             req_tdata[rcm_pkg::SAMPLE_BITS+31:rcm_pkg::SAMPLE_BITS]);
         if (rsp_tvalid && rsp_tready)
            meter.check_result(rcm_pkg::kind_type'(rsp_tuser[0]), rsp_tdata,
                               rsp_tuser[1]);
      end
   end

   // result sink: random stall bursts and one long hold on request
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("timeout: stimulus or results stalled");
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic [31:0] wide_random();
      logic [31:0] v;
      v = $urandom;
      return v >> $urandom_range(0, 32);
   endfunction

   // adc code biased toward the rails and midscale
   function automatic logic [rcm_pkg::SAMPLE_BITS-1:0] random_code();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return rcm_pkg::SAMPLE_MID;
         3: return rcm_pkg::SAMPLE_MID - 1'b1;
         default: return rcm_pkg::SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // count register value, mostly short, sometimes extreme or zero
   function automatic logic [7:0] random_count();
      case ($urandom_range(0, 19))
         0: return 8'd255;
         1: return 8'd0;
         2: return 8'($urandom);
         default: return 8'($urandom_range(1, 6));
      endcase
   endfunction

   // one request transaction, with an optional idle burst ahead of it
   task automatic send_item(input rcm_pkg::action_type act,
                            input logic [rcm_pkg::SAMPLE_BITS-1:0] adc_code,
                            input logic [31:0] arg);
      int gap;
      gap = (src_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {6'd0, arg, adc_code};
      do @(posedge clock); while (!req_tready);
      if (act != rcm_pkg::ACT_UNUSED)
         items_driven++;
   endtask

   task automatic send_random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 84)
         send_item(rcm_pkg::ACT_SAMPLE, random_code(), $urandom);
      else if (pick < 90)
         send_item(rcm_pkg::ACT_ARM, rcm_pkg::SAMPLE_BITS'($urandom), wide_random());
      else if (pick < 96)
         send_item(rcm_pkg::ACT_RESTORE, rcm_pkg::SAMPLE_BITS'($urandom), wide_random());
      else
         send_item(rcm_pkg::ACT_UNUSED, rcm_pkg::SAMPLE_BITS'($urandom), $urandom);
   endtask

   task automatic write_register(input logic [7:0] index, input logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop valid, wait for every expected result and for the divider to finish
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (meter.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] spp, input logic [7:0] ppr, input int count);
      settle();
      src_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0)
         write_register(8'($urandom_range(2, 255)), 8'($urandom));
      write_register(rcm_pkg::REG_SAMPLES_PER_PERIOD, spp);
      write_register(rcm_pkg::REG_PERIODS_PER_REPORT, ppr);
      repeat (count) send_random_item();
   endtask

   initial begin
      logic [7:0] fixed_spp[5];
      logic [7:0] fixed_ppr[5];
      int         fixed_len[5];
      int         start_items;

      meter = new();
      fixed_spp = '{8'd1, 8'd255, 8'd1, 8'd0, 8'd200};
      fixed_ppr = '{8'd1, 8'd1, 8'd255, 8'd0, 8'd2};
      fixed_len = '{40, 280, 280, 30, 60};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed items at the reset register values
      send_item(rcm_pkg::ACT_RESTORE, '0, 32'd0);
      send_item(rcm_pkg::ACT_UNUSED, '1, 32'hFFFF_FFFF);
      send_item(rcm_pkg::ACT_ARM, '0, 32'hFFFF_FFFF);
      send_item(rcm_pkg::ACT_ARM, '0, 32'h0100_0000);
      send_item(rcm_pkg::ACT_ARM, '0, 32'd0);
      send_item(rcm_pkg::ACT_SAMPLE, '0, 32'd0);
      send_item(rcm_pkg::ACT_SAMPLE, '1, 32'hFFFF_FFFF);
      send_item(rcm_pkg::ACT_SAMPLE, rcm_pkg::SAMPLE_MID, 32'hAAAA_AAAA);
      send_item(rcm_pkg::ACT_SAMPLE, rcm_pkg::SAMPLE_MID - 1'b1, 32'h5555_5555);
      send_item(rcm_pkg::ACT_SAMPLE, rcm_pkg::SAMPLE_MID + 1'b1, 32'd0);
      send_item(rcm_pkg::ACT_SAMPLE, 10'h2AA, 32'd0);
      send_item(rcm_pkg::ACT_SAMPLE, 10'h155, 32'd0);
      send_item(rcm_pkg::ACT_RESTORE, '0, 32'hFFFF_FFFF);
      send_item(rcm_pkg::ACT_RESTORE, '0, 32'd0);

      // register extremes; the first phase also backs up the result path
      // and, with the scale still zero, gives saturated reports
      for (int i = 0; i < 5; i++) begin
         if (i == 0) begin
            settle();
            long_hold_req = 1'b1;
         end
         run_phase(fixed_spp[i], fixed_ppr[i], fixed_len[i]);
      end

      // random phases with mostly short periods and windows
      start_items = items_driven;
      while (items_driven < start_items + RANDOM_ITEMS)
         run_phase(random_count(), random_count(), $urandom_range(20, 80));

      // no idling from here: align the counters, then a short tail at full rate
      settle();
      src_gaps = 1'b0;
      sink_gaps = 1'b0;
      write_register(rcm_pkg::REG_SAMPLES_PER_PERIOD, 8'd1);
      write_register(rcm_pkg::REG_PERIODS_PER_REPORT, 8'd1);
      send_item(rcm_pkg::ACT_SAMPLE, random_code(), $urandom);
      settle();
      write_register(rcm_pkg::REG_SAMPLES_PER_PERIOD, 8'd4);
      write_register(rcm_pkg::REG_PERIODS_PER_REPORT, 8'd3);
      send_item(rcm_pkg::ACT_RESTORE, '0, wide_random());
      repeat (TAIL_ITEMS) send_random_item();

      // drain and finish
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (meter.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      meter.close_out();
      $display("covered %0d samples, %0d arms, %0d restores, %0d ignored, %0d csr writes",
               meter.samples, meter.arms, meter.restores, meter.ignored, meter.reg_writes);
      $display("checked %0d reports and %0d calibrations (%0d saturated), %0d mismatches",
               meter.reports, meter.calibrations, meter.saturations, meter.mismatches);
      if (meter.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
